### rtl/lav_pkg.sv
// Shared types, constants and a helper function of the look-at view matrix block.
package lav_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_UP_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_UP_Z = 2'd2;

  localparam logic [1:0] ROW_U = 2'd0;
  localparam logic [1:0] ROW_V = 2'd1;
  localparam logic [1:0] ROW_W = 2'd2;
  localparam int         ROWS  = 3;

  localparam logic signed [15:0] UP_X_RESET = 16'sd0;
  localparam logic signed [15:0] UP_Y_RESET = 16'sd0;
  localparam logic signed [15:0] UP_Z_RESET = 16'sd16384;

  localparam int MAG_W      = 32;
  localparam int MSB_W      = 5;
  localparam int NRM_W      = 21;
  localparam int NRM_MSB    = 20;
  localparam int SQR_W      = 2 * NRM_W;
  localparam int SQ_W       = SQR_W + 2;
  localparam int SQRT_STEPS = SQ_W / 2;
  localparam int LEN_W      = NRM_W + 1;
  localparam int Q_BITS     = 15;
  localparam int FRAC       = 14;
  localparam int NUM_W      = LEN_W + Q_BITS;
  localparam int ACC_W      = 50;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } vec16_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec32_t;

  typedef struct packed {
    vec32_t pos;
    vec16_t w;
    logic   degen;
  } side_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
  } in_req_t;

  typedef struct packed {
    logic [1:0]         axis_row;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;
    logic signed [31:0] offset;
    logic               degenerate;
    logic               last;
  } out_res_t;

  function automatic logic signed [ACC_W-1:0] rdiv14(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] r;
    mag = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    r   = (mag + ACC_W'(1 << (FRAC - 1))) >> FRAC;
    return x[ACC_W-1] ? -$signed(r) : $signed(r);
  endfunction

endpackage

### rtl/lav_norm.sv
// Pipelined vector normalizer: range shift, square root and per-component division.
module lav_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  lav_pkg::vec32_t in_vec,
  input  lav_pkg::side_t  in_side,
  output logic          out_valid,
  output logic          out_ok,
  output lav_pkg::vec16_t out_vec,
  output lav_pkg::side_t  out_side
);
  import lav_pkg::*;

  typedef struct packed {
    logic [2:0][NRM_W-1:0] m;
    logic [2:0]            neg;
    logic                  nz;
    side_t                 side;
  } nst_t;

  function automatic logic [MSB_W-1:0] msb_of(input logic [MAG_W-1:0] v);
    logic [MSB_W-1:0] p;
    p = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) p = MSB_W'(i);
    end
    return p;
  endfunction

  logic signed [MAG_W-1:0] a_c [3];
  logic [2:0][MAG_W-1:0]   mag_c;
  logic [2:0]              neg_c;
  logic [MAG_W-1:0]        mx_c;

  assign a_c[0] = in_vec.x;
  assign a_c[1] = in_vec.y;
  assign a_c[2] = in_vec.z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_c[i] = a_c[i][MAG_W-1];
      mag_c[i] = neg_c[i] ? (MAG_W'(0) - MAG_W'(a_c[i])) : MAG_W'(a_c[i]);
    end
    mx_c = mag_c[0];
    if (mag_c[1] > mx_c) mx_c = mag_c[1];
    if (mag_c[2] > mx_c) mx_c = mag_c[2];
  end

  logic                  s0_v_r, s1_v_r, s2_v_r, s3_v_r;
  logic [2:0][MAG_W-1:0] s0_mag_r, s1_mag_r;
  logic [2:0]            s0_neg_r, s1_neg_r;
  logic [MAG_W-1:0]      s0_mx_r;
  side_t                 s0_side_r, s1_side_r;
  logic [MSB_W-1:0]      s1_msb_r;
  logic                  s1_nz_r;
  nst_t                  s2_r, s2_nxt, s3_r;
  logic [2:0][SQR_W-1:0] s3_sq_r;

  always_comb begin
    s2_nxt.neg  = s1_neg_r;
    s2_nxt.nz   = s1_nz_r;
    s2_nxt.side = s1_side_r;
    for (int i = 0; i < 3; i++) begin
      if (s1_msb_r >= MSB_W'(NRM_MSB)) begin
        s2_nxt.m[i] = NRM_W'(s1_mag_r[i] >> (s1_msb_r - MSB_W'(NRM_MSB)));
      end else begin
        s2_nxt.m[i] = NRM_W'(s1_mag_r[i] << (MSB_W'(NRM_MSB) - s1_msb_r));
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_mag_r  <= mag_c;
    s0_neg_r  <= neg_c;
    s0_mx_r   <= mx_c;
    s0_side_r <= in_side;
    s1_mag_r  <= s0_mag_r;
    s1_neg_r  <= s0_neg_r;
    s1_side_r <= s0_side_r;
    s1_msb_r  <= msb_of(s0_mx_r);
    s1_nz_r   <= (s0_mx_r != '0);
    s2_r      <= s2_nxt;
    s3_r      <= s2_r;
    for (int i = 0; i < 3; i++) begin
      s3_sq_r[i] <= SQR_W'(s2_r.m[i]) * SQR_W'(s2_r.m[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s0_v_r <= in_valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  logic [SQ_W-1:0]     sq_rem_r [SQRT_STEPS+1];
  logic [SQ_W-1:0]     sq_res_r [SQRT_STEPS+1];
  nst_t                sq_c_r   [SQRT_STEPS+1];
  logic [SQRT_STEPS:0] sq_v_r;

  always_ff @(posedge clk) begin
    sq_rem_r[0] <= SQ_W'(s3_sq_r[0]) + SQ_W'(s3_sq_r[1]) + SQ_W'(s3_sq_r[2]);
    sq_res_r[0] <= '0;
    sq_c_r[0]   <= s3_r;
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (SQ_W - 2 - 2 * k);
    logic [SQ_W-1:0] trial;
    assign trial = sq_res_r[k] + BIT;
    always_ff @(posedge clk) begin
      if (sq_rem_r[k] >= trial) begin
        sq_rem_r[k+1] <= sq_rem_r[k] - trial;
        sq_res_r[k+1] <= (sq_res_r[k] >> 1) + BIT;
      end else begin
        sq_rem_r[k+1] <= sq_rem_r[k];
        sq_res_r[k+1] <= sq_res_r[k] >> 1;
      end
      sq_c_r[k+1] <= sq_c_r[k];
    end
  end

  logic [LEN_W-1:0] len_c;
  assign len_c = sq_res_r[SQRT_STEPS][LEN_W-1:0];

  logic [2:0][NUM_W-1:0]  dv_rem_r [Q_BITS+1];
  logic [2:0][Q_BITS-1:0] dv_q_r   [Q_BITS+1];
  logic [LEN_W-1:0]       dv_len_r [Q_BITS+1];
  nst_t                   dv_c_r   [Q_BITS+1];
  logic [Q_BITS:0]        dv_v_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_r[0][i] <= (NUM_W'(sq_c_r[SQRT_STEPS].m[i]) << FRAC) + NUM_W'(len_c >> 1);
    end
    dv_q_r[0]   <= '0;
    dv_len_r[0] <= len_c;
    dv_c_r[0]   <= sq_c_r[SQRT_STEPS];
  end

  for (genvar j = 0; j < Q_BITS; j++) begin : g_div
    localparam int SH = Q_BITS - 1 - j;
    logic [NUM_W-1:0] dsr;
    assign dsr = NUM_W'(dv_len_r[j]) << SH;
    always_ff @(posedge clk) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_r[j][i] >= dsr) begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i] - dsr;
          dv_q_r[j+1][i]   <= dv_q_r[j][i] | (Q_BITS'(1) << SH);
        end else begin
          dv_rem_r[j+1][i] <= dv_rem_r[j][i];
          dv_q_r[j+1][i]   <= dv_q_r[j][i];
        end
      end
      dv_len_r[j+1] <= dv_len_r[j];
      dv_c_r[j+1]   <= dv_c_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= '0;
      dv_v_r <= '0;
    end else begin
      sq_v_r <= {sq_v_r[SQRT_STEPS-1:0], s3_v_r};
      dv_v_r <= {dv_v_r[Q_BITS-1:0], sq_v_r[SQRT_STEPS]};
    end
  end

  logic signed [15:0] comp_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (!dv_c_r[Q_BITS].nz) begin
        comp_c[i] = '0;
      end else if (dv_c_r[Q_BITS].neg[i]) begin
        comp_c[i] = -$signed({1'b0, dv_q_r[Q_BITS][i]});
      end else begin
        comp_c[i] = $signed({1'b0, dv_q_r[Q_BITS][i]});
      end
    end
  end

  assign out_valid = dv_v_r[Q_BITS];
  assign out_ok    = dv_c_r[Q_BITS].nz;
  assign out_vec.x = comp_c[0];
  assign out_vec.y = comp_c[1];
  assign out_vec.z = comp_c[2];
  assign out_side  = dv_c_r[Q_BITS].side;

endmodule

### rtl/look_at_view_matrix.sv
// Top level of the look-at view matrix builder.
// The u row is on the outputs first after a request is accepted,
// followed by the v row and then the w row on consecutive strobes.
// busy rises after each accepted request and holds off the next one until the
// gap counter has run down, since the single result port carries three rows each.
// Synchronous active-low reset clears the pipeline and sets up to (0, 0, 1.0).
module look_at_view_matrix (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  lav_pkg::in_req_t                in_req,
  output logic                            out_strobe,
  output lav_pkg::out_res_t               out_data,
  input  logic                            cfg_we,
  input  logic [lav_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lav_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import lav_pkg::*;

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(32767)) return 16'sh7fff;
    if (x < ACC_W'(-32768)) return 16'sh8000;
    return x[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] x);
    if (x > ACC_W'(64'sh7fffffff)) return 32'sh7fffffff;
    if (x < ACC_W'(-64'sh80000000)) return 32'sh80000000;
    return x[31:0];
  endfunction

  logic signed [15:0] up_x_r, up_y_r, up_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_x_r <= UP_X_RESET;
      up_y_r <= UP_Y_RESET;
      up_z_r <= UP_Z_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UP_X: up_x_r <= $signed(cfg_data);
        CFG_UP_Y: up_y_r <= $signed(cfg_data);
        CFG_UP_Z: up_z_r <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  logic       accept;
  logic [1:0] gap_r;

  assign accept = start & ~busy;
  assign busy   = (gap_r != 2'd0) | ~rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gap_r <= 2'd0;
    end else if (accept) begin
      gap_r <= 2'(ROWS - 1);
    end else if (gap_r != 2'd0) begin
      gap_r <= gap_r - 2'd1;
    end
  end

  logic   in_v_r;
  vec32_t in_vec_r;
  side_t  in_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    in_vec_r.x      <= 32'(in_req.dir_x);
    in_vec_r.y      <= 32'(in_req.dir_y);
    in_vec_r.z      <= 32'(in_req.dir_z);
    in_side_r.pos.x <= in_req.pos_x;
    in_side_r.pos.y <= in_req.pos_y;
    in_side_r.pos.z <= in_req.pos_z;
    in_side_r.w     <= '0;
    in_side_r.degen <= 1'b0;
  end

  logic   n1_v, n1_ok;
  vec16_t n1_vec;
  side_t  n1_side;

  lav_norm u_norm_w (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_v_r),
    .in_vec   (in_vec_r),
    .in_side  (in_side_r),
    .out_valid(n1_v),
    .out_ok   (n1_ok),
    .out_vec  (n1_vec),
    .out_side (n1_side)
  );

  logic               x1_v_r, x2_v_r;
  logic signed [31:0] x1_p_r [6];
  side_t              x1_side_r, x2_side_r;
  vec32_t             x2_c_r;

  always_ff @(posedge clk) begin
    x1_p_r[0]       <= n1_vec.y * up_z_r;
    x1_p_r[1]       <= n1_vec.z * up_y_r;
    x1_p_r[2]       <= n1_vec.z * up_x_r;
    x1_p_r[3]       <= n1_vec.x * up_z_r;
    x1_p_r[4]       <= n1_vec.x * up_y_r;
    x1_p_r[5]       <= n1_vec.y * up_x_r;
    x1_side_r.pos   <= n1_side.pos;
    x1_side_r.w     <= n1_vec;
    x1_side_r.degen <= ~n1_ok;
    x2_c_r.x        <= x1_p_r[0] - x1_p_r[1];
    x2_c_r.y        <= x1_p_r[2] - x1_p_r[3];
    x2_c_r.z        <= x1_p_r[4] - x1_p_r[5];
    x2_side_r       <= x1_side_r;
  end

  logic   n2_v, n2_ok;
  vec16_t n2_vec;
  side_t  n2_side;

  lav_norm u_norm_u (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (x2_v_r),
    .in_vec   (x2_c_r),
    .in_side  (x2_side_r),
    .out_valid(n2_v),
    .out_ok   (n2_ok),
    .out_vec  (n2_vec),
    .out_side (n2_side)
  );

  logic               v1_v_r, v2_v_r, d1_v_r, d2_v_r;
  logic signed [31:0] v1_p_r [6];
  vec16_t             v1_u_r;
  side_t              v1_side_r;
  vec16_t             ax_r [3];
  vec16_t             d1_ax_r [3];
  vec32_t             v2_pos_r;
  logic               v2_degen_r, d1_degen_r, d2_degen_r;
  logic signed [47:0] d1_p_r [3][3];
  logic signed [ACC_W-1:0] d2_sum_r [3];
  vec16_t             d2_ax_r [3];
  logic signed [ACC_W-1:0] vr_c [3];
  logic signed [15:0] vq_c [3];

  always_comb begin
    vr_c[0] = ACC_W'(v1_p_r[0]) - ACC_W'(v1_p_r[1]);
    vr_c[1] = ACC_W'(v1_p_r[2]) - ACC_W'(v1_p_r[3]);
    vr_c[2] = ACC_W'(v1_p_r[4]) - ACC_W'(v1_p_r[5]);
    for (int i = 0; i < 3; i++) begin
      vq_c[i] = sat16(rdiv14(vr_c[i]));
    end
  end

  always_ff @(posedge clk) begin
    v1_p_r[0]       <= n2_side.w.y * n2_vec.z;
    v1_p_r[1]       <= n2_side.w.z * n2_vec.y;
    v1_p_r[2]       <= n2_side.w.z * n2_vec.x;
    v1_p_r[3]       <= n2_side.w.x * n2_vec.z;
    v1_p_r[4]       <= n2_side.w.x * n2_vec.y;
    v1_p_r[5]       <= n2_side.w.y * n2_vec.x;
    v1_u_r          <= n2_vec;
    v1_side_r.pos   <= n2_side.pos;
    v1_side_r.w     <= n2_side.w;
    v1_side_r.degen <= n2_side.degen | ~n2_ok;

    if (v1_side_r.degen) begin
      ax_r[0] <= '0;
      ax_r[1] <= '0;
      ax_r[2] <= '0;
    end else begin
      ax_r[0]   <= v1_u_r;
      ax_r[1].x <= vq_c[0];
      ax_r[1].y <= vq_c[1];
      ax_r[1].z <= vq_c[2];
      ax_r[2]   <= v1_side_r.w;
    end
    v2_pos_r   <= v1_side_r.pos;
    v2_degen_r <= v1_side_r.degen;

    for (int r = 0; r < 3; r++) begin
      d1_p_r[r][0] <= ax_r[r].x * v2_pos_r.x;
      d1_p_r[r][1] <= ax_r[r].y * v2_pos_r.y;
      d1_p_r[r][2] <= ax_r[r].z * v2_pos_r.z;
      d1_ax_r[r]   <= ax_r[r];
      d2_sum_r[r]  <= ACC_W'(d1_p_r[r][0]) + ACC_W'(d1_p_r[r][1]) + ACC_W'(d1_p_r[r][2]);
      d2_ax_r[r]   <= d1_ax_r[r];
    end
    d1_degen_r <= v2_degen_r;
    d2_degen_r <= d1_degen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_v_r <= 1'b0;
      x2_v_r <= 1'b0;
      v1_v_r <= 1'b0;
      v2_v_r <= 1'b0;
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
    end else begin
      x1_v_r <= n1_v;
      x2_v_r <= x1_v_r;
      v1_v_r <= n2_v;
      v2_v_r <= v1_v_r;
      d1_v_r <= v2_v_r;
      d2_v_r <= d1_v_r;
    end
  end

  out_res_t   hold_r [3];
  logic [1:0] row_r;
  logic       out_v_r;

  always_ff @(posedge clk) begin
    if (d2_v_r) begin
      for (int r = 0; r < 3; r++) begin
        hold_r[r].axis_row   <= 2'(r);
        hold_r[r].axis_x     <= d2_ax_r[r].x;
        hold_r[r].axis_y     <= d2_ax_r[r].y;
        hold_r[r].axis_z     <= d2_ax_r[r].z;
        hold_r[r].offset     <= sat32(-rdiv14(d2_sum_r[r]));
        hold_r[r].degenerate <= d2_degen_r;
        hold_r[r].last       <= (2'(r) == ROW_W);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      row_r   <= ROW_U;
    end else if (d2_v_r) begin
      out_v_r <= 1'b1;
      row_r   <= ROW_U;
    end else if (out_v_r) begin
      if (row_r == ROW_W) begin
        out_v_r <= 1'b0;
      end else begin
        row_r <= row_r + 2'd1;
      end
    end
  end

  assign out_strobe = out_v_r;
  assign out_data   = hold_r[row_r];

endmodule

### rtl/lav_chk.sv
// Port-level checker for the look-at view matrix block and its bind statement.
module lav_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic                            out_strobe,
  input lav_pkg::out_res_t               out_data
);
  import lav_pkg::*;

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted request");

  a_row_u_then_v: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.axis_row == ROW_U |=> out_strobe && out_data.axis_row == ROW_V)
    else $error("u row was not followed by the v row");

  a_row_v_then_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.axis_row == ROW_V |=> out_strobe && out_data.axis_row == ROW_W)
    else $error("v row was not followed by the w row");

  a_last_on_w: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_data.last == (out_data.axis_row == ROW_W))
    else $error("last flag does not match the w row");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.degenerate |-> out_data.axis_x == 0 && out_data.axis_y == 0 &&
      out_data.axis_z == 0 && out_data.offset == 0)
    else $error("degenerate row carries nonzero values");

endmodule

bind look_at_view_matrix lav_chk u_lav_chk (.*);

### sim/tb_top.sv
// Self-checking testbench for the look-at view matrix builder.
`timescale 1ns / 100ps

module tb_top;
  import lav_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 120;

  typedef logic [2:0][63:0] trip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  in_req_t in_req = '0;
  logic out_strobe;
  out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  in_req_t pending_reqs[$];
  out_res_t rows_due[$];
  logic signed [15:0] up_vec[3];
  int send_idle = 0;
  int err_count = 0;
  int req_count = 0;
  int row_count = 0;
  int degen_count = 0;

  look_at_view_matrix dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_strobe(out_strobe), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint unsigned mag(longint x);
    return x < 0 ? longint'(-x) : longint'(x);
  endfunction

  function automatic longint round_q14(longint x);
    longint unsigned r;
    r = (mag(x) + 64'd8192) >> 14;
    return x < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic bit unit_vec(input trip_t a, output trip_t o);
    longint unsigned m[3];
    longint unsigned mx, n2, len, q;
    mx = 0;
    n2 = 0;
    o = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = mag($signed(a[i]));
      if (m[i] > mx) mx = m[i];
    end
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 21)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 20)) begin
      for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) n2 += m[i] * m[i];
    len = int_sqrt(n2);
    for (int i = 0; i < 3; i++) begin
      q = (m[i] * 64'd16384 + len / 2) / len;
      if (q > 32767) q = 32767;
      o[i] = $signed(a[i]) < 0 ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic trip_t cross3(trip_t a, trip_t b);
    trip_t c;
    c[0] = $signed(a[1]) * $signed(b[2]) - $signed(a[2]) * $signed(b[1]);
    c[1] = $signed(a[2]) * $signed(b[0]) - $signed(a[0]) * $signed(b[2]);
    c[2] = $signed(a[0]) * $signed(b[1]) - $signed(a[1]) * $signed(b[0]);
    return c;
  endfunction

  task automatic predict_rows(in_req_t r);
    trip_t d, p, up, c, vr;
    trip_t ax[3];
    bit degen;
    longint acc, off, t;
    out_res_t row;
    d[0] = 64'(r.dir_x); d[1] = 64'(r.dir_y); d[2] = 64'(r.dir_z);
    p[0] = 64'(r.pos_x); p[1] = 64'(r.pos_y); p[2] = 64'(r.pos_z);
    for (int i = 0; i < 3; i++) up[i] = longint'(up_vec[i]);
    for (int k = 0; k < 3; k++) ax[k] = '0;
    degen = 1'b0;
    if (!unit_vec(d, ax[2])) begin
      degen = 1'b1;
    end else begin
      c = cross3(ax[2], up);
      if (!unit_vec(c, ax[0])) begin
        degen = 1'b1;
      end else begin
        vr = cross3(ax[2], ax[0]);
        for (int i = 0; i < 3; i++) begin
          t = round_q14($signed(vr[i]));
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          ax[1][i] = t;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      off = 0;
      if (degen) begin
        ax[k] = '0;
      end else begin
        acc = 0;
        for (int i = 0; i < 3; i++) acc += $signed(ax[k][i]) * $signed(p[i]);
        off = -round_q14(acc);
        if (off > 64'sh7FFFFFFF) off = 64'sh7FFFFFFF;
        if (off < -64'sh80000000) off = -64'sh80000000;
      end
      row.axis_row = k[1:0];
      row.axis_x = ax[k][0][15:0];
      row.axis_y = ax[k][1][15:0];
      row.axis_z = ax[k][2][15:0];
      row.offset = off[31:0];
      row.degenerate = degen;
      row.last = (k == 2);
      rows_due.push_back(row);
    end
    if (degen) degen_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_rows(in_req);
        req_count++;
      end
      if (!start || !busy) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle) begin
          in_req <= pending_reqs.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      row_count++;
      if (rows_due.size() == 0) begin
        $error("unexpected row %0d", out_data.axis_row);
        err_count++;
      end else begin
        out_res_t e;
        e = rows_due.pop_front();
        if (out_data.axis_row !== e.axis_row) begin
          $error("axis_row: expected %0d, got %0d", e.axis_row, out_data.axis_row);
          err_count++;
        end
        if (out_data.axis_x !== e.axis_x) begin
          $error("axis_x: expected %0d, got %0d", e.axis_x, out_data.axis_x);
          err_count++;
        end
        if (out_data.axis_y !== e.axis_y) begin
          $error("axis_y: expected %0d, got %0d", e.axis_y, out_data.axis_y);
          err_count++;
        end
        if (out_data.axis_z !== e.axis_z) begin
          $error("axis_z: expected %0d, got %0d", e.axis_z, out_data.axis_z);
          err_count++;
        end
        if (out_data.offset !== e.offset) begin
          $error("offset: expected %0d, got %0d", e.offset, out_data.offset);
          err_count++;
        end
        if (out_data.degenerate !== e.degenerate) begin
          $error("degenerate: expected %0d, got %0d", e.degenerate, out_data.degenerate);
          err_count++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_data.last);
          err_count++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == CFG_UP_X) up_vec[0] = val;
    else if (idx == CFG_UP_Y) up_vec[1] = val;
    else if (idx == CFG_UP_Z) up_vec[2] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_up(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    write_reg(CFG_UP_X, x);
    write_reg(CFG_UP_Y, y);
    write_reg(CFG_UP_Z, z);
  endtask

  task automatic add_req(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz,
                         logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    in_req_t r;
    r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
    r.pos_x = px; r.pos_y = py; r.pos_z = pz;
    pending_reqs.push_back(r);
  endtask

  task automatic add_random(int n);
    logic [15:0] d[3];
    int kind;
    int ax;
    for (int j = 0; j < n; j++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 3; i++) begin
        if (kind < 6) d[i] = 16'($urandom);
        else if (kind < 8) d[i] = 16'($urandom_range(7)) - 16'd3;
        else d[i] = 16'd0;
      end
      if (kind >= 8) begin
        ax = $urandom_range(2);
        d[ax] = 16'($urandom);
      end
      add_req(d[0], d[1], d[2], $urandom, $urandom, $urandom);
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk); while (pending_reqs.size() != 0 || start || rows_due.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin
    up_vec[0] = UP_X_RESET;
    up_vec[1] = UP_Y_RESET;
    up_vec[2] = UP_Z_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    send_idle = 0;
    add_req(16'd0, 16'd0, 16'd0, 32'h7FFFFFFF, 32'h80000000, 32'd0);
    add_req(16'd0, 16'd0, 16'd16384, 32'd65536, 32'd0, 32'd0);
    add_req(16'd0, 16'd0, 16'h8000, 32'd0, 32'd0, 32'd0);
    add_req(16'd1, 16'd0, 16'd16384, 32'd1, 32'd2, 32'd3);
    add_req(16'h8000, 16'h8000, 16'h8000, 32'h80000000, 32'h80000000, 32'h80000000);
    add_req(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_req(16'h7FFF, 16'h8000, 16'd0, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add_req(16'd16384, 16'd0, 16'd0, 32'h00010000, 32'h00020000, 32'h00030000);
    add_req(16'd0, 16'hFFFF, 16'd0, 32'hFFFF0000, 32'd0, 32'd12345);
    add_random(40);
    wait_idle();

    set_up(16'd0, 16'd16384, 16'd0);
    write_reg(CFG_UNUSED, 16'h1234);
    send_idle = 58;
    add_req(16'd0, 16'd5, 16'd0, 32'd7, 32'd8, 32'd9);
    add_req(16'd0, 16'h8000, 16'd0, 32'd7, 32'd8, 32'd9);
    add_random(60);
    wait_idle();

    set_up(16'h8000, 16'h7FFF, 16'h8000);
    send_idle = 0;
    for (int c = 0; c < 4; c++) begin
      add_random(15);
      wait_idle();
    end

    set_up(16'd0, 16'd0, 16'd0);
    send_idle = 33;
    add_req(16'd100, 16'd200, 16'd300, 32'd1, 32'd1, 32'd1);
    add_random(15);
    wait_idle();

    set_up(16'($urandom), 16'($urandom), 16'($urandom));
    send_idle = 58;
    add_random(50);
    wait_idle();

    set_up(16'd0, 16'd0, 16'd16384);
    send_idle = 33;
    add_random(30);
    wait_idle();

    if (rows_due.size() != 0) begin
      $error("%0d rows never arrived", rows_due.size());
      err_count++;
    end
    $display("Sent %0d requests over six up-vector settings, %0d of them degenerate.",
             req_count, degen_count);
    $display("Checked %0d result rows.", row_count);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
